/* hw/rtl/sfm_pkg.sv */
package sfm_pkg;

  localparam int TABLE_POINTS_DEF = 16;

  localparam int SETPOINT_W = 16;
  localparam int SLOT_W     = 4;
  localparam int FREQ_W     = 31;
  localparam int SLAVE_W    = 8;
  localparam int PIU_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // serial divider: numerator covers |offset * dy| + |dx|/2, divisor a 16-bit value
  localparam int DIV_W  = 48;
  localparam int DEN_W  = 16;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int DX_W   = SETPOINT_W + 1;
  localparam int DY_W   = FREQ_W + 1;
  localparam int PROD_W = DX_W + DY_W;
  localparam int SUM_W  = DIV_W + 2;

  localparam logic [DIV_W-1:0]  RECIP_NUM = DIV_W'(655360000);
  localparam logic [FREQ_W-1:0] FREQ_MAX  = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG_VALID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 2'd3;

  typedef logic [3:0] op_t;
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_ACCEPT     = 4'd1;
  localparam op_t OP_TBL_INIT   = 4'd2;
  localparam op_t OP_STEP       = 4'd3;
  localparam op_t OP_DIFF       = 4'd4;
  localparam op_t OP_MUL        = 4'd5;
  localparam op_t OP_TBL_LOAD   = 4'd6;
  localparam op_t OP_RECIP_LOAD = 4'd7;
  localparam op_t OP_Q_LOAD     = 4'd8;
  localparam op_t OP_DIV_STEP   = 4'd9;
  localparam op_t OP_FIN        = 4'd10;
  localparam op_t OP_HOLD       = 4'd11;
  localparam op_t OP_EMIT       = 4'd12;

  typedef logic [3:0] cond_t;
  localparam cond_t C_NEVER      = 4'd0;
  localparam cond_t C_ALWAYS     = 4'd1;
  localparam cond_t C_NO_IN      = 4'd2;
  localparam cond_t C_IS_LOAD    = 4'd3;
  localparam cond_t C_CFG_OFF    = 4'd4;
  localparam cond_t C_DIV_MODE   = 4'd5;
  localparam cond_t C_FEW_POINTS = 4'd6;
  localparam cond_t C_SP_LE_X    = 4'd7;
  localparam cond_t C_LAST       = 4'd8;
  localparam cond_t C_DX_ZERO    = 4'd9;
  localparam cond_t C_SP_ZERO    = 4'd10;
  localparam cond_t C_DIV_RUN    = 4'd11;
  localparam cond_t C_OUT_BUSY   = 4'd12;

  typedef logic [4:0] step_t;
  localparam step_t S_ACCEPT = 5'd0;
  localparam step_t S_LOOK   = 5'd8;
  localparam step_t S_MATCH  = 5'd11;
  localparam step_t S_DIVL   = 5'd14;
  localparam step_t S_RECIP  = 5'd16;
  localparam step_t S_RDIV   = 5'd18;
  localparam step_t S_HOLD   = 5'd20;
  localparam step_t S_EMIT   = 5'd21;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic is_load;
    logic cfg_off;
    logic div_mode;
    logic few_points;
    logic sp_le_x;
    logic last;
    logic dx_zero;
    logic sp_zero;
    logic div_run;
    logic out_busy;
  } sfm_status_t;

  // control program: jump to target when the condition holds, else fall through
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t uc;
    unique case (s)
      5'd0:  uc = '{OP_ACCEPT,     C_NO_IN,      S_ACCEPT};
      5'd1:  uc = '{OP_NOP,        C_IS_LOAD,    S_ACCEPT};
      5'd2:  uc = '{OP_NOP,        C_CFG_OFF,    S_HOLD};
      5'd3:  uc = '{OP_NOP,        C_DIV_MODE,   S_RECIP};
      5'd4:  uc = '{OP_TBL_INIT,   C_FEW_POINTS, S_HOLD};
      5'd5:  uc = '{OP_NOP,        C_NEVER,      S_ACCEPT};
      5'd6:  uc = '{OP_STEP,       C_NEVER,      S_ACCEPT};
      5'd7:  uc = '{OP_NOP,        C_NEVER,      S_ACCEPT};
      5'd8:  uc = '{OP_NOP,        C_SP_LE_X,    S_MATCH};
      5'd9:  uc = '{OP_STEP,       C_LAST,       S_HOLD};
      5'd10: uc = '{OP_NOP,        C_ALWAYS,     S_LOOK};
      5'd11: uc = '{OP_DIFF,       C_DX_ZERO,    S_HOLD};
      5'd12: uc = '{OP_MUL,        C_NEVER,      S_ACCEPT};
      5'd13: uc = '{OP_TBL_LOAD,   C_NEVER,      S_ACCEPT};
      5'd14: uc = '{OP_DIV_STEP,   C_DIV_RUN,    S_DIVL};
      5'd15: uc = '{OP_FIN,        C_ALWAYS,     S_EMIT};
      5'd16: uc = '{OP_NOP,        C_SP_ZERO,    S_HOLD};
      5'd17: uc = '{OP_RECIP_LOAD, C_NEVER,      S_ACCEPT};
      5'd18: uc = '{OP_DIV_STEP,   C_DIV_RUN,    S_RDIV};
      5'd19: uc = '{OP_Q_LOAD,     C_ALWAYS,     S_DIVL};
      5'd20: uc = '{OP_HOLD,       C_NEVER,      S_ACCEPT};
      5'd21: uc = '{OP_EMIT,       C_OUT_BUSY,   S_EMIT};
      5'd22: uc = '{OP_NOP,        C_ALWAYS,     S_ACCEPT};
      default: uc = '{OP_NOP,      C_ALWAYS,     S_ACCEPT};
    endcase
    return uc;
  endfunction

endpackage

/* hw/rtl/setpoint_to_frequency_map.sv */
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    kind, setpoint, point_slot, point_index,
//                                        point_frequency
// out       out   out_valid / out_ready  frequency, updated
// cfg       in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a load beat writes the point table and returns to accept; a convert beat runs
// the 48-step serial divider (twice in divide mode, once in table mode), in
// table mode after a table walk over the points with one table read port
// reset clears the config registers, the held frequency and the sequencer;
// table points are undefined until loaded
// a pending result holds the sequencer in the emit step; no beat is taken meanwhile
module setpoint_to_frequency_map
  import sfm_pkg::*;
#(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [SETPOINT_W-1:0] setpoint,
  input  logic [SLOT_W-1:0]     point_slot,
  input  logic [SETPOINT_W-1:0] point_index,
  input  logic [FREQ_W-1:0]     point_frequency,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FREQ_W-1:0]     frequency,
  output logic                  updated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  op_t         op;
  sfm_status_t status;

  sfm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  sfm_datapath #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .status          (status),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .setpoint        (setpoint),
    .point_slot      (point_slot),
    .point_index     (point_index),
    .point_frequency (point_frequency),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frequency       (frequency),
    .updated         (updated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

endmodule

/* hw/rtl/sfm_div.sv */
module sfm_div
  import sfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             step,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [DIV_W-1:0] quo,
  output logic             run
);

  logic [DIV_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // one quotient bit per step, quotient bits shift in behind the numerator
  always_comb begin
    rem_sh  = {rem, acc[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    ge      = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNT_W'(DIV_W);
    end else if (step && run) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc <= num;
      rem <= '0;
      dvs <= den;
    end else if (step && run) begin
      acc <= {acc[DIV_W-2:0], ge};
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quo = acc;
  assign run = cnt != '0;

endmodule

/* hw/rtl/sfm_datapath.sv */
module sfm_datapath
  import sfm_pkg::*;
#(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  op_t                   op,
  output sfm_status_t           status,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [SETPOINT_W-1:0] setpoint,
  input  logic [SLOT_W-1:0]     point_slot,
  input  logic [SETPOINT_W-1:0] point_index,
  input  logic [FREQ_W-1:0]     point_frequency,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FREQ_W-1:0]     frequency,
  output logic                  updated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_POINTS);
  localparam int CW = (AW + 1 > PIU_W) ? AW + 1 : PIU_W;
  localparam int EW = (AW > SLOT_W) ? AW : SLOT_W;

  logic               config_valid;
  logic               divide_mode;
  logic [SLAVE_W-1:0] slave_count;
  logic [PIU_W-1:0]   points_in_use;

  logic [SETPOINT_W-1:0] table_x [TABLE_POINTS];
  logic [FREQ_W-1:0]     table_y [TABLE_POINTS];
  logic [SETPOINT_W-1:0] rd_x;
  logic [FREQ_W-1:0]     rd_y;

  logic                  load_item;
  logic [SETPOINT_W-1:0] sp;
  logic [AW-1:0]         idx;
  logic [SETPOINT_W-1:0] prev_x;
  logic [FREQ_W-1:0]     prev_y;
  logic signed [DX_W-1:0]   dx;
  logic signed [DX_W-1:0]   off;
  logic signed [DY_W-1:0]   dy;
  logic signed [PROD_W-1:0] prod;
  logic [FREQ_W-1:0]     base;
  logic                  neg;
  logic [FREQ_W-1:0]     res;
  logic [FREQ_W-1:0]     held;

  logic                  in_fire;
  logic                  emit_fire;
  logic [EW:0]           slot_ext;
  logic                  slot_ok;
  logic [CW-1:0]         piu_ext;
  logic [CW-1:0]         n_eff;
  logic [PROD_W-1:0]     abs_prod;
  logic [DX_W-1:0]       abs_dx;
  logic                  div_load;
  logic [DIV_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic [DIV_W-1:0]      quo;
  logic                  div_run;
  logic signed [SUM_W-1:0] q_signed;
  logic signed [SUM_W-1:0] sum;
  logic [FREQ_W-1:0]     clamped;

  assign in_ready  = op == OP_ACCEPT;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign emit_fire = (op == OP_EMIT) && !(out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      config_valid  <= 1'b0;
      divide_mode   <= 1'b0;
      slave_count   <= '0;
      points_in_use <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONFIG_VALID:  config_valid  <= cfg_data[0];
        REG_DIVIDE_MODE:   divide_mode   <= cfg_data[0];
        REG_SLAVE_COUNT:   slave_count   <= cfg_data[SLAVE_W-1:0];
        REG_POINTS_IN_USE: points_in_use <= cfg_data[PIU_W-1:0];
        default: ;
      endcase
    end
  end

  // point table; a slot past the table depth is dropped
  always_comb begin
    slot_ext = (EW + 1)'(point_slot);
    slot_ok  = slot_ext < (EW + 1)'(TABLE_POINTS);
  end

  always_ff @(posedge clk) begin
    if (in_fire && kind && slot_ok) begin
      table_x[slot_ext[AW-1:0]] <= point_index;
      table_y[slot_ext[AW-1:0]] <= point_frequency;
    end
    rd_x <= table_x[idx];
    rd_y <= table_y[idx];
  end

  always_comb begin
    piu_ext  = CW'(points_in_use);
    n_eff    = (piu_ext > CW'(TABLE_POINTS)) ? CW'(TABLE_POINTS) : piu_ext;
    abs_prod = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    abs_dx   = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
  end

  always_comb begin
    status.in_valid   = in_valid;
    status.is_load    = load_item;
    status.cfg_off    = !config_valid;
    status.div_mode   = divide_mode;
    status.few_points = n_eff < CW'(2);
    status.sp_le_x    = sp <= rd_x;
    status.last       = (CW'(idx) + CW'(1)) >= n_eff;
    status.dx_zero    = rd_x == prev_x;
    status.sp_zero    = sp == '0;
    status.div_run    = div_run;
    status.out_busy   = out_valid && !out_ready;
  end

  // divider operands for the three load points of the program
  always_comb begin
    div_load = 1'b0;
    div_num  = RECIP_NUM;
    div_den  = DEN_W'(slave_count) + DEN_W'(1);
    unique case (op)
      OP_TBL_LOAD: begin
        div_load = 1'b1;
        div_num  = DIV_W'(abs_prod) + DIV_W'(abs_dx >> 1);
        div_den  = abs_dx[DEN_W-1:0];
      end
      OP_RECIP_LOAD: begin
        div_load = 1'b1;
      end
      OP_Q_LOAD: begin
        div_load = 1'b1;
        div_num  = quo + DIV_W'(sp >> 1);
        div_den  = sp;
      end
      default: ;
    endcase
  end

  sfm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .load (div_load),
    .step (op == OP_DIV_STEP),
    .num  (div_num),
    .den  (div_den),
    .quo  (quo),
    .run  (div_run)
  );

  // signed rounded quotient plus the segment base, clamped to the output range
  always_comb begin
    q_signed = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    sum      = q_signed + $signed({{(SUM_W - FREQ_W){1'b0}}, base});
    if (sum[SUM_W-1]) begin
      clamped = '0;
    end else if (|sum[SUM_W-2:FREQ_W]) begin
      clamped = FREQ_MAX;
    end else begin
      clamped = sum[FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      load_item <= kind;
      sp        <= setpoint;
    end
    unique case (op)
      OP_TBL_INIT: idx <= '0;
      OP_STEP: begin
        prev_x <= rd_x;
        prev_y <= rd_y;
        idx    <= idx + 1'b1;
      end
      OP_DIFF: begin
        dx   <= $signed({1'b0, rd_x}) - $signed({1'b0, prev_x});
        off  <= $signed({1'b0, sp}) - $signed({1'b0, prev_x});
        dy   <= $signed({1'b0, rd_y}) - $signed({1'b0, prev_y});
        base <= prev_y;
      end
      OP_MUL:      prod <= PROD_W'(off) * PROD_W'(dy);
      OP_TBL_LOAD: neg  <= prod[PROD_W-1] ^ dx[DX_W-1];
      OP_Q_LOAD: begin
        neg  <= 1'b0;
        base <= '0;
      end
      OP_FIN:      res <= clamped;
      OP_HOLD:     res <= held;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      held      <= res;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      frequency <= res;
      updated   <= res != held;
    end
  end

endmodule

/* hw/rtl/sfm_seq.sv */
module sfm_seq
  import sfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sfm_status_t status,
  output op_t         op
);

  step_t  step;
  step_t  step_next;
  ucode_t uc;
  logic   take;

  always_comb begin
    uc = ucode_rom(step);
    unique case (uc.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_IN:      take = !status.in_valid;
      C_IS_LOAD:    take = status.is_load;
      C_CFG_OFF:    take = status.cfg_off;
      C_DIV_MODE:   take = status.div_mode;
      C_FEW_POINTS: take = status.few_points;
      C_SP_LE_X:    take = status.sp_le_x;
      C_LAST:       take = status.last;
      C_DX_ZERO:    take = status.dx_zero;
      C_SP_ZERO:    take = status.sp_zero;
      C_DIV_RUN:    take = status.div_run;
      C_OUT_BUSY:   take = status.out_busy;
      default:      take = 1'b0;
    endcase
    step_next = take ? uc.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

  assign op = uc.op;

endmodule

/* hw/rtl/sfm_check.sv */
module sfm_check
  import sfm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FREQ_W-1:0] frequency,
  input logic              updated
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frequency) && $stable(updated))
    else $error("result beat changed while stalled");

  // the sequencer leaves the accept step right after taking a beat
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  // a table load passes through the load check step back to accept and brings out no result
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind && !out_valid |=> !out_valid ##1 in_ready)
    else $error("table load misbehaved");

  // out of reset the block waits for a beat with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind setpoint_to_frequency_map sfm_check u_check (.*);
